FILE: rtl/pist_pkg.sv
// Shared types and constants for the pointer id slot table.
// No dependencies; used by every module of the block.
package pist_pkg;

  localparam int unsigned SLOTS   = 16;
  localparam int unsigned SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CNT_W   = $clog2(SLOTS + 1);
  localparam int unsigned ID_W    = 32;
  localparam int unsigned IDENT_W = ID_W - 1;
  localparam int unsigned FUNC_W  = 2;
  localparam int unsigned SLOT_OUT_W = 4;
  localparam int unsigned CNT_OUT_W  = 5;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ACQUIRE     = 2'd0,
    FUNC_FIND        = 2'd1,
    FUNC_RELEASE     = 2'd2,
    FUNC_RELEASE_ALL = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_e;

  // Commands from controller to datapath.
  typedef struct packed {
    logic load;  // capture the incoming beat
    logic exec;  // run the operation and load the result register
  } cmd_t;

endpackage

FILE: rtl/pist_ctrl.sv
// Controller FSM for the pointer id slot table.
// Depends on pist_pkg; drives the command struct of pist_dp.
module pist_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output pist_pkg::cmd_t  cmd_o
);

  pist_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;
  logic             out_free;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != pist_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    unique case (state_q)
      pist_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = pist_pkg::ST_EXEC;
        end
      end
      pist_pkg::ST_EXEC: begin
        // Hold the operation until the result register can take it.
        if (out_free) begin
          cmd_o.exec  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = pist_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = pist_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pist_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

FILE: rtl/pist_dp.sv
// Datapath for the pointer id slot table: slot store, match, allocate, count.
// Depends on pist_pkg; commanded by pist_ctrl.
module pist_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  pist_pkg::cmd_t                      cmd_i,
  input  logic [pist_pkg::FUNC_W-1:0]         func_i,
  input  logic signed [pist_pkg::ID_W-1:0]    pointer_id_i,
  output logic [pist_pkg::SLOT_OUT_W-1:0]     slot_o,
  output logic                                slot_valid_o,
  output logic [pist_pkg::CNT_OUT_W-1:0]      active_count_o
);

  // Captured operation.
  pist_pkg::func_e                     op_q;
  logic                                neg_q;
  logic [pist_pkg::IDENT_W-1:0]        id_q;

  // Slot store.
  logic [pist_pkg::IDENT_W-1:0]        ident_q [pist_pkg::SLOTS];
  logic [pist_pkg::SLOTS-1:0]          used_q, used_d;
  logic [pist_pkg::CNT_W-1:0]          cnt_q, cnt_d;

  // Search results.
  logic [pist_pkg::SLOTS-1:0]          match;
  logic                                hit_found, free_found;
  logic [pist_pkg::SLOT_W-1:0]         hit_idx, free_idx;

  // Result.
  logic                                res_valid;
  logic [pist_pkg::SLOT_W-1:0]         res_slot;
  logic                                wr_en;

  // Result register.
  logic [pist_pkg::SLOT_OUT_W-1:0]     slot_q;
  logic                                slot_valid_q;
  logic [pist_pkg::CNT_OUT_W-1:0]      count_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= pist_pkg::func_e'(func_i);
      neg_q <= pointer_id_i[pist_pkg::ID_W-1];
      id_q  <= pointer_id_i[pist_pkg::IDENT_W-1:0];
    end
  end

  always_comb begin
    for (int k = 0; k < pist_pkg::SLOTS; k++) begin
      match[k] = used_q[k] && (ident_q[k] == id_q);
    end
  end

  // Lowest set bit wins: scan downward so the last assignment is the lowest.
  always_comb begin
    hit_found  = 1'b0;
    hit_idx    = '0;
    free_found = 1'b0;
    free_idx   = '0;
    for (int k = pist_pkg::SLOTS - 1; k >= 0; k--) begin
      if (match[k]) begin
        hit_found = 1'b1;
        hit_idx   = pist_pkg::SLOT_W'(k);
      end
      if (!used_q[k]) begin
        free_found = 1'b1;
        free_idx   = pist_pkg::SLOT_W'(k);
      end
    end
  end

  always_comb begin
    used_d    = used_q;
    cnt_d     = cnt_q;
    res_valid = 1'b0;
    res_slot  = '0;
    wr_en     = 1'b0;
    unique case (op_q)
      pist_pkg::FUNC_ACQUIRE: begin
        if (!neg_q) begin
          if (hit_found) begin
            res_valid = 1'b1;
            res_slot  = hit_idx;
          end else if (free_found) begin
            res_valid        = 1'b1;
            res_slot         = free_idx;
            used_d[free_idx] = 1'b1;
            wr_en            = 1'b1;
            cnt_d            = cnt_q + pist_pkg::CNT_W'(1);
          end
        end
      end
      pist_pkg::FUNC_FIND: begin
        if (!neg_q && hit_found) begin
          res_valid = 1'b1;
          res_slot  = hit_idx;
        end
      end
      pist_pkg::FUNC_RELEASE: begin
        if (!neg_q && hit_found) begin
          res_valid       = 1'b1;
          res_slot        = hit_idx;
          used_d[hit_idx] = 1'b0;
          cnt_d           = cnt_q - pist_pkg::CNT_W'(1);
        end
      end
      pist_pkg::FUNC_RELEASE_ALL: begin
        used_d = '0;
        cnt_d  = '0;
      end
      default: begin
        used_d = used_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
      cnt_q  <= '0;
    end else if (cmd_i.exec) begin
      used_q <= used_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && wr_en) begin
      ident_q[free_idx] <= id_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      slot_q       <= pist_pkg::SLOT_OUT_W'(res_slot);
      slot_valid_q <= res_valid;
      count_q      <= pist_pkg::CNT_OUT_W'(cnt_d);
    end
  end

  assign slot_o         = slot_q;
  assign slot_valid_o   = slot_valid_q;
  assign active_count_o = count_q;

endmodule

FILE: rtl/pointer_id_slot_table_unit.sv
// Top level of the pointer id slot table.
// Depends on pist_pkg, pist_ctrl and pist_dp.
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+----------------------------------
//   in      | input     | in_valid_i / in_stall_o  | func_i, pointer_id_i
//   out     | output    | out_valid_o / out_stall_i| slot_o, slot_valid_o, active_count_o
//
// Each beat is handled in two steps: capture, then the parallel compare
// across all slots, the lowest-index pick and the table update. Capture and
// result register are apart, so a new beat is taken while a result waits.
// Reset clears every used flag and the slot count; identifiers stay unknown
// until written and are only compared where the used flag is set.
// A stalled result holds the operation in its execute cycle until the
// result register frees up; the table is not touched before then.
module pointer_id_slot_table_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [pist_pkg::FUNC_W-1:0]         func_i,
  input  logic signed [pist_pkg::ID_W-1:0]    pointer_id_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [pist_pkg::SLOT_OUT_W-1:0]     slot_o,
  output logic                                slot_valid_o,
  output logic [pist_pkg::CNT_OUT_W-1:0]      active_count_o
);

  pist_pkg::cmd_t cmd;

  // Sequence capture and execute; own the result valid flag.
  pist_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  // Hold the slot store, match and allocate, keep the count.
  pist_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .func_i         (func_i),
    .pointer_id_i   (pointer_id_i),
    .slot_o         (slot_o),
    .slot_valid_o   (slot_valid_o),
    .active_count_o (active_count_o)
  );

endmodule
